@@ src/rmcsr_pkg.sv @@
// Shared types, codes and constants of the machine-mode CSR file.
`default_nettype none

package rmcsr_pkg;

  typedef enum logic [1:0] {
    ErrOk       = 2'd0,
    ErrReadOnly = 2'd1,
    ErrNoCsr    = 2'd2
  } err_e;

  typedef enum logic [1:0] {
    WrNone      = 2'd0,
    WrOverwrite = 2'd1,
    WrClear     = 2'd2,
    WrSet       = 2'd3
  } wr_kind_e;

  localparam logic FuncTick = 1'b1;

  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned InTdataW  = 48;
  localparam int unsigned OutTdataW = 40;

  localparam logic [CfgIdxW-1:0] CfgVendorId = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgArchId   = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgImplId   = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgHartId   = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgConfPtr  = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgIsaReset = 3'd5;

  localparam logic [31:0] IsaResetValue = 32'h4000_0000;
  localparam logic [1:0]  RoAddrPrefix  = 2'b11;

  localparam logic [11:0] CsrMstatus    = 12'h300;
  localparam logic [11:0] CsrMisa       = 12'h301;
  localparam logic [11:0] CsrMie        = 12'h304;
  localparam logic [11:0] CsrMtvec      = 12'h305;
  localparam logic [11:0] CsrMstatush   = 12'h310;
  localparam logic [11:0] CsrMscratch   = 12'h340;
  localparam logic [11:0] CsrMepc       = 12'h341;
  localparam logic [11:0] CsrMcause     = 12'h342;
  localparam logic [11:0] CsrMtval      = 12'h343;
  localparam logic [11:0] CsrMip        = 12'h344;
  localparam logic [11:0] CsrMcycle     = 12'hB00;
  localparam logic [11:0] CsrMcycleh    = 12'hB80;
  localparam logic [11:0] CsrMinstret   = 12'hB02;
  localparam logic [11:0] CsrMinstreth  = 12'hB82;
  localparam logic [11:0] CsrMvendorid  = 12'hF11;
  localparam logic [11:0] CsrMarchid    = 12'hF12;
  localparam logic [11:0] CsrMimpid     = 12'hF13;
  localparam logic [11:0] CsrMhartid    = 12'hF14;
  localparam logic [11:0] CsrMconfigptr = 12'hF15;

  typedef struct packed {
    logic load;
    logic exec;
  } dp_cmd_t;

  typedef struct packed {
    logic is_tick;
  } dp_status_t;

  function automatic logic [31:0] merge(input logic [31:0] old, input logic [31:0] mask,
                                        input logic [31:0] val);
    return (old & ~mask) | (val & mask);
  endfunction

endpackage

`default_nettype wire

@@ src/riscv_machine_csr_file.sv @@
// Top level of the RV32 machine-mode CSR file.
//
// channel   direction  contents
// s_axis    in         CSR access or clock tick (tuser selects)
// m_axis    out        read data and error code, one per access
// cfg       in         identifier register writes by index
//
// The controller's accept/execute sequence takes an item in idle and executes it in execute;
// no new item is taken until the previous one has executed.
// An access waits in execute while the previous result has not been taken; ticks do not.
// Reset clears all CSRs and counters, misa loads 0x40000000.
// The config port is always ready.
`default_nettype none

module riscv_machine_csr_file
  import rmcsr_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  // [11:0] csr_address, [12] read_request, [14:13] write_kind, [46:15] write_data, [47] 0
  input  wire logic [InTdataW-1:0]  s_axis_tdata,
  // [0] func
  input  wire logic                 s_axis_tuser,
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  // [31:0] read_data, [33:32] error_code, [39:34] 0
  output logic [OutTdataW-1:0]      m_axis_tdata,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [31:0]          cfg_data_i
);

  dp_cmd_t     cmd;
  dp_status_t  status;
  logic [31:0] rd_data;
  err_e        err;

  rmcsr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .cmd_o      (cmd),
    .status_i   (status)
  );

  rmcsr_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .status_o   (status),
    .in_tdata_i (s_axis_tdata),
    .in_tuser_i (s_axis_tuser),
    .cfg_we_i   (cfg_valid_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .rd_data_o  (rd_data),
    .err_o      (err)
  );

  assign cfg_ready_o  = 1'b1;
  assign m_axis_tdata = {6'b0, err, rd_data};

endmodule

`default_nettype wire

@@ src/rmcsr_ctrl.sv @@
// Controller of the CSR file: transaction sequencing and result valid.
`default_nettype none

module rmcsr_ctrl
  import rmcsr_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output dp_cmd_t         cmd_o,
  input  wire dp_status_t status_i
);

  typedef enum logic [1:0] {
    StIdle = 2'b01,
    StExec = 2'b10
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   can_exec;

  always_comb begin
    can_exec    = (state_q == StExec) && (status_i.is_tick || !out_valid_q || out_ready_i);
    in_ready_o  = (state_q == StIdle);
    cmd_o.load  = (state_q == StIdle) && in_valid_i;
    cmd_o.exec  = can_exec;
    out_valid_d = (out_valid_q && !out_ready_i) || (can_exec && !status_i.is_tick);
    state_d     = state_q;
    case (state_q)
      StIdle: begin
        if (in_valid_i) state_d = StExec;
      end
      StExec: begin
        if (can_exec) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

@@ src/rmcsr_datapath.sv @@
// Datapath of the CSR file: item latch, CSR storage, write merge and result register.
`default_nettype none

module rmcsr_datapath
  import rmcsr_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire dp_cmd_t              cmd_i,
  output dp_status_t                status_o,
  input  wire logic [InTdataW-1:0]  in_tdata_i,
  input  wire logic                 in_tuser_i,
  input  wire logic                 cfg_we_i,
  input  wire logic [CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [31:0]          cfg_data_i,
  output logic [31:0]               rd_data_o,
  output err_e                      err_o
);

  // latched item
  logic        func_q;
  logic [11:0] addr_q;
  logic        rd_q;
  logic [1:0]  kind_q;
  logic [31:0] wdata_q;

  // identifiers
  logic [31:0] vendor_q, arch_q, impl_q, hart_q, cfgptr_q;

  // CSRs
  logic [31:0] scratch_q, scratch_d, isa_q, isa_d, epc_q, epc_d;
  logic [31:0] cause_q, cause_d, tval_q, tval_d, mip_q, mip_d;
  logic [31:0] mie_q, mie_d, mtvec_q, mtvec_d;
  logic [3:0]  status_q, status_d;
  logic [63:0] cycle_q, cycle_d, instret_q, instret_d;

  logic [31:0] rd_data_q, rd_data_d;
  err_e        err_q, err_d;

  logic [31:0] mask, val, old, nv, status_word;
  logic        ro, noop, hit, do_wr;

  always_comb begin
    case (wr_kind_e'(kind_q))
      WrOverwrite: begin mask = '1;      val = wdata_q; end
      WrClear:     begin mask = wdata_q; val = '0;      end
      WrSet:       begin mask = wdata_q; val = '1;      end
      default:     begin mask = '0;      val = '0;      end
    endcase

    status_word = 32'(status_q[0]) << 3 | 32'(status_q[1]) << 7 | 32'(status_q[3:2]) << 11;

    ro   = (addr_q[11:10] == RoAddrPrefix) && (mask != '0);
    noop = !rd_q && (wr_kind_e'(kind_q) == WrNone);
    hit  = 1'b1;
    case (addr_q)
      CsrMstatus:    old = status_word;
      CsrMstatush:   old = '0;
      CsrMisa:       old = isa_q;
      CsrMie:        old = mie_q;
      CsrMtvec:      old = mtvec_q;
      CsrMscratch:   old = scratch_q;
      CsrMepc:       old = epc_q;
      CsrMcause:     old = cause_q;
      CsrMtval:      old = tval_q;
      CsrMip:        old = mip_q;
      CsrMcycle:     old = cycle_q[31:0];
      CsrMcycleh:    old = cycle_q[63:32];
      CsrMinstret:   old = instret_q[31:0];
      CsrMinstreth:  old = instret_q[63:32];
      CsrMvendorid:  old = vendor_q;
      CsrMarchid:    old = arch_q;
      CsrMimpid:     old = impl_q;
      CsrMhartid:    old = hart_q;
      CsrMconfigptr: old = cfgptr_q;
      default: begin
        old = '0;
        hit = 1'b0;
      end
    endcase
    nv    = merge(old, mask, val);
    do_wr = cmd_i.exec && (func_q != FuncTick) && !ro && !noop;

    scratch_d = scratch_q;
    isa_d     = isa_q;
    epc_d     = epc_q;
    cause_d   = cause_q;
    tval_d    = tval_q;
    mip_d     = mip_q;
    mie_d     = mie_q;
    mtvec_d   = mtvec_q;
    status_d  = status_q;
    cycle_d   = cycle_q;
    instret_d = instret_q;

    if (cmd_i.exec && (func_q == FuncTick)) begin
      cycle_d   = cycle_q + 64'd1;
      instret_d = instret_q + 64'd1;
    end

    if (do_wr) begin
      case (addr_q)
        CsrMstatus:   status_d = {nv[12:11], nv[7], nv[3]};
        CsrMisa:      isa_d = nv;
        CsrMie:       mie_d = nv;
        CsrMtvec:     mtvec_d = nv;
        CsrMscratch:  scratch_d = nv;
        CsrMepc:      epc_d = nv;
        CsrMcause:    cause_d = nv;
        CsrMtval:     tval_d = nv;
        CsrMip:       mip_d = nv;
        CsrMcycle:    cycle_d[31:0] = nv;
        CsrMcycleh:   cycle_d[63:32] = nv;
        CsrMinstret:  instret_d[31:0] = nv;
        CsrMinstreth: instret_d[63:32] = nv;
        default: ;
      endcase
    end

    if (ro) begin
      err_d     = ErrReadOnly;
      rd_data_d = '0;
    end else if (noop) begin
      err_d     = ErrOk;
      rd_data_d = '0;
    end else if (!hit) begin
      err_d     = ErrNoCsr;
      rd_data_d = '0;
    end else begin
      err_d     = ErrOk;
      rd_data_d = old;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q  <= in_tuser_i;
      addr_q  <= in_tdata_i[11:0];
      rd_q    <= in_tdata_i[12];
      kind_q  <= in_tdata_i[14:13];
      wdata_q <= in_tdata_i[46:15];
    end
    if (cmd_i.exec && (func_q != FuncTick)) begin
      rd_data_q <= rd_data_d;
      err_q     <= err_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vendor_q  <= '0;
      arch_q    <= '0;
      impl_q    <= '0;
      hart_q    <= '0;
      cfgptr_q  <= '0;
      scratch_q <= '0;
      isa_q     <= IsaResetValue;
      epc_q     <= '0;
      cause_q   <= '0;
      tval_q    <= '0;
      mip_q     <= '0;
      mie_q     <= '0;
      mtvec_q   <= '0;
      status_q  <= '0;
      cycle_q   <= '0;
      instret_q <= '0;
    end else begin
      if (cfg_we_i) begin
        // misa reset value is restored by reset itself, so its register write has no effect
        case (cfg_index_i)
          CfgVendorId: vendor_q <= cfg_data_i;
          CfgArchId:   arch_q   <= cfg_data_i;
          CfgImplId:   impl_q   <= cfg_data_i;
          CfgHartId:   hart_q   <= cfg_data_i;
          CfgConfPtr:  cfgptr_q <= cfg_data_i;
          CfgIsaReset: ;
          default: ;
        endcase
      end
      scratch_q <= scratch_d;
      isa_q     <= isa_d;
      epc_q     <= epc_d;
      cause_q   <= cause_d;
      tval_q    <= tval_d;
      mip_q     <= mip_d;
      mie_q     <= mie_d;
      mtvec_q   <= mtvec_d;
      status_q  <= status_d;
      cycle_q   <= cycle_d;
      instret_q <= instret_d;
    end
  end

  assign status_o.is_tick = (func_q == FuncTick);
  assign rd_data_o        = rd_data_q;
  assign err_o            = err_q;

endmodule

`default_nettype wire
